// ===== sv/itlb_pkg.sv =====
// Shared types, codes and constants for the instruction TLB lookup.
// Used by itlb_cell and instruction_tlb_lookup; depends on nothing.
`default_nettype none

package itlb_pkg;

  localparam int unsigned VA_W       = 64;
  localparam int unsigned PA_W       = 41;
  localparam int unsigned CTX_W      = 13;
  localparam int unsigned ENTRY_IDX_W = 6;
  localparam int unsigned PPN_W      = PA_W - CTX_W;
  localparam int unsigned VPN_W      = VA_W - CTX_W;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CTX_W;
  localparam int unsigned FSR_W      = 4;

  localparam int unsigned VALID_POS  = 63;
  localparam int unsigned SIZE_POS   = 61;
  localparam int unsigned PRIV_POS   = 2;

  localparam logic [VA_W-1:0] MASK_8K   = 64'hffff_ffff_ffff_e000;
  localparam logic [VA_W-1:0] MASK_64K  = 64'hffff_ffff_ffff_0000;
  localparam logic [VA_W-1:0] MASK_512K = 64'hffff_ffff_fff8_0000;
  localparam logic [VA_W-1:0] MASK_4M   = 64'hffff_ffff_ffc0_0000;

  localparam logic [FSR_W-1:0] FSR_OVERFLOW = 4'h2;
  localparam logic [FSR_W-1:0] FSR_PROT     = 4'h9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_IMMU_ENABLE     = 1'b0;
  localparam cfg_idx_t REG_CURRENT_CONTEXT = 1'b1;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_FAULT = 2'd1,
    OUT_MISS  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    SZ_8K   = 2'd0,
    SZ_64K  = 2'd1,
    SZ_512K = 2'd2,
    SZ_4M   = 2'd3
  } page_size_t;

  // One transaction as it travels down the row of entry cells.
  typedef struct packed {
    logic                   lookup;
    logic                   write;
    logic [VA_W-1:0]        va;
    logic                   user;
    logic [ENTRY_IDX_W-1:0] index;
    logic [VA_W-1:0]        tag;
    logic [VA_W-1:0]        data;
    logic                   hit;
    logic                   priv;
    logic [PA_W-1:0]        pa;
  } probe_t;

  function automatic logic [VA_W-1:0] size_mask(input page_size_t size);
    logic [VA_W-1:0] m;
    unique case (size)
      SZ_8K:   m = MASK_8K;
      SZ_64K:  m = MASK_64K;
      SZ_512K: m = MASK_512K;
      SZ_4M:   m = MASK_4M;
      default: m = MASK_8K;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/itlb_cell.sv =====
// One TLB entry cell: holds a tag/data pair, compares a passing transaction
// against it and hands the transaction to the next cell. Depends on itlb_pkg.
`default_nettype none

module itlb_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [itlb_pkg::CTX_W-1:0]  cur_ctx,
  input  wire logic                        probe_in_valid,
  input  wire itlb_pkg::probe_t            probe_in,
  output logic                             probe_out_valid,
  output itlb_pkg::probe_t                 probe_out
);

  localparam bit IN_RANGE = (CELL_IDX < (1 << itlb_pkg::ENTRY_IDX_W));

  logic                           entry_valid_r;
  logic [itlb_pkg::VPN_W-1:0]     tag_vpn_r;
  logic [itlb_pkg::CTX_W-1:0]     tag_ctx_r;
  itlb_pkg::page_size_t           size_r;
  logic                           priv_r;
  logic [itlb_pkg::PPN_W-1:0]     ppn_r;

  logic                           pvalid_r;
  itlb_pkg::probe_t               probe_r;
  itlb_pkg::probe_t               probe_nxt;

  logic                           wr_hit;
  logic                           match;
  logic [itlb_pkg::VA_W-1:0]      mask;
  logic [itlb_pkg::PA_W-1:0]      mask_pa;

  assign wr_hit = IN_RANGE && probe_in_valid && probe_in.write &&
                  (probe_in.index == itlb_pkg::ENTRY_IDX_W'(CELL_IDX));

  assign mask    = itlb_pkg::size_mask(size_r);
  assign mask_pa = mask[itlb_pkg::PA_W-1:0];
  assign match   = entry_valid_r && (tag_ctx_r == cur_ctx) &&
                   ((probe_in.va & mask) ==
                    ({tag_vpn_r, {itlb_pkg::CTX_W{1'b0}}} & mask));

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.lookup && !probe_in.hit && match) begin
      probe_nxt.hit  = 1'b1;
      probe_nxt.priv = priv_r;
      probe_nxt.pa   = ({ppn_r, {itlb_pkg::CTX_W{1'b0}}} & mask_pa) |
                       (probe_in.va[itlb_pkg::PA_W-1:0] & ~mask_pa);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
      pvalid_r      <= 1'b0;
    end else begin
      pvalid_r <= probe_in_valid;
      if (wr_hit) begin
        entry_valid_r <= probe_in.data[itlb_pkg::VALID_POS];
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    if (wr_hit) begin
      tag_vpn_r <= probe_in.tag[itlb_pkg::VA_W-1:itlb_pkg::CTX_W];
      tag_ctx_r <= probe_in.tag[itlb_pkg::CTX_W-1:0];
      size_r    <= itlb_pkg::page_size_t'(
                     probe_in.data[itlb_pkg::SIZE_POS+1:itlb_pkg::SIZE_POS]);
      priv_r    <= probe_in.data[itlb_pkg::PRIV_POS];
      ppn_r     <= probe_in.data[itlb_pkg::PA_W-1:itlb_pkg::CTX_W];
    end
  end

  assign probe_out_valid = pvalid_r;
  assign probe_out       = probe_r;

endmodule

`default_nettype wire

// ===== sv/instruction_tlb_lookup.sv =====
// Instruction TLB top level: row of entry cells, fault/tag-access registers
// and result register. Depends on itlb_pkg and itlb_cell.
// A transaction walks the cell row one entry per cycle, then its result is
// registered; busy holds off the next one until it has left the row.
// Reset: all entries invalid, fault status, tag access and config cleared.
// Results appear for one cycle on out_valid; the receiver cannot stall.
`default_nettype none

module instruction_tlb_lookup #(
  parameter int unsigned TLB_ENTRIES = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [itlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [itlb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_mode,
  input  wire logic [63:0]                        in_virt_addr,
  input  wire logic                               in_user_access,
  input  wire logic [5:0]                         in_entry_index,
  input  wire logic [63:0]                        in_entry_tag,
  input  wire logic [63:0]                        in_entry_data,
  output logic                                    out_valid,
  output logic [1:0]                              out_outcome,
  output logic [63:0]                             out_phys_addr,
  output logic                                    out_exec_allowed,
  output logic [3:0]                              out_fault_status_out,
  output logic [63:0]                             out_tag_access_out
);

  logic                               immu_enable_r;
  logic [itlb_pkg::CTX_W-1:0]         ctx_r;
  logic                               busy_r;
  logic                               busy_nxt;
  logic [itlb_pkg::FSR_W-1:0]         fsr_r;
  logic [itlb_pkg::FSR_W-1:0]         fsr_nxt;
  logic [itlb_pkg::VA_W-1:0]          tag_access_r;
  logic [itlb_pkg::VA_W-1:0]          tag_access_nxt;

  logic                               out_valid_r;
  itlb_pkg::outcome_t                 outcome_r;
  itlb_pkg::outcome_t                 outcome_nxt;
  logic [itlb_pkg::VA_W-1:0]          pa_r;
  logic [itlb_pkg::VA_W-1:0]          pa_nxt;
  logic                               exec_r;
  logic                               exec_nxt;

  logic                               accept;
  logic                               link_valid [0:TLB_ENTRIES];
  itlb_pkg::probe_t                   link_probe [0:TLB_ENTRIES];
  logic                               tail_valid;
  itlb_pkg::probe_t                   tail;

  assign accept = start && !busy_r;

  always_comb begin
    link_valid[0]        = accept;
    link_probe[0].lookup = !in_mode && immu_enable_r;
    link_probe[0].write  = in_mode;
    link_probe[0].va     = in_virt_addr;
    link_probe[0].user   = in_user_access;
    link_probe[0].index  = in_entry_index;
    link_probe[0].tag    = in_entry_tag;
    link_probe[0].data   = in_entry_data;
    link_probe[0].hit    = 1'b0;
    link_probe[0].priv   = 1'b0;
    link_probe[0].pa     = '0;
  end

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    itlb_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .cur_ctx         (ctx_r),
      .probe_in_valid  (link_valid[g]),
      .probe_in        (link_probe[g]),
      .probe_out_valid (link_valid[g+1]),
      .probe_out       (link_probe[g+1])
    );
  end

  assign tail_valid = link_valid[TLB_ENTRIES];
  assign tail       = link_probe[TLB_ENTRIES];

  always_comb begin
    busy_nxt       = busy_r;
    fsr_nxt        = fsr_r;
    tag_access_nxt = tag_access_r;
    outcome_nxt    = itlb_pkg::OUT_OK;
    pa_nxt         = '0;
    exec_nxt       = 1'b0;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tail_valid) begin
      busy_nxt = 1'b0;
      if (tail.write) begin
        outcome_nxt = itlb_pkg::OUT_OK;
      end else if (!tail.lookup) begin
        pa_nxt   = tail.va;
        exec_nxt = 1'b1;
      end else if (tail.hit && tail.priv && tail.user) begin
        fsr_nxt     = ((fsr_r != '0) ? itlb_pkg::FSR_OVERFLOW : '0) | itlb_pkg::FSR_PROT;
        outcome_nxt = itlb_pkg::OUT_FAULT;
      end else if (tail.hit) begin
        pa_nxt   = {{(itlb_pkg::VA_W-itlb_pkg::PA_W){1'b0}}, tail.pa};
        exec_nxt = 1'b1;
      end else begin
        tag_access_nxt = {tail.va[itlb_pkg::VA_W-1:itlb_pkg::CTX_W], ctx_r};
        outcome_nxt    = itlb_pkg::OUT_MISS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      immu_enable_r <= 1'b0;
      ctx_r         <= '0;
      busy_r        <= 1'b0;
      fsr_r         <= '0;
      tag_access_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          itlb_pkg::REG_IMMU_ENABLE:     immu_enable_r <= cfg_wdata[0];
          itlb_pkg::REG_CURRENT_CONTEXT: ctx_r         <= cfg_wdata;
          default: ;
        endcase
      end
      busy_r       <= busy_nxt;
      fsr_r        <= fsr_nxt;
      tag_access_r <= tag_access_nxt;
      out_valid_r  <= tail_valid;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r <= outcome_nxt;
    pa_r      <= pa_nxt;
    exec_r    <= exec_nxt;
  end

  assign busy                 = busy_r;
  assign out_valid            = out_valid_r;
  assign out_outcome          = outcome_r;
  assign out_phys_addr        = pa_r;
  assign out_exec_allowed     = exec_r;
  assign out_fault_status_out = fsr_r;
  assign out_tag_access_out   = tag_access_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted transaction did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result presented while a transaction is still in the row");

  a_exec_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && exec_r) |-> (outcome_r == itlb_pkg::OUT_OK))
    else $error("execute granted on a fault or miss");

  a_fail_no_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (outcome_r != itlb_pkg::OUT_OK)) |-> (pa_r == '0))
    else $error("nonzero physical address on a fault or miss");

  a_fault_fsr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (outcome_r == itlb_pkg::OUT_FAULT)) |-> (fsr_r[0] && fsr_r[3]))
    else $error("protection fault without fault status update");

endmodule

`default_nettype wire

// ===== tb/instruction_tlb_lookup_test.sv =====
// Self-checking testbench for instruction_tlb_lookup: directed table, then random phases;
// results checked against typed rows or a TLB predictor. Depends on itlb_pkg and the RTL.
`default_nettype none

module instruction_tlb_lookup_test;

  localparam int TLB_ENTRIES    = 64;
  localparam int MAX_GAP        = 100;
  localparam int WATCHDOG_LIMIT = 8 * (TLB_ENTRIES + 1 + MAX_GAP);
  localparam int N_DIRECTED     = 22;
  localparam int RANDOM_PHASES  = 15;
  localparam int PHASE_ITEMS    = 102;

  localparam logic MODE_FETCH = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam logic [63:0] PA_MASK = 64'h0000_01ff_ffff_ffff;

  typedef struct packed {
    logic                             mode;
    logic [63:0]                      va;
    logic                             user;
    logic [itlb_pkg::ENTRY_IDX_W-1:0] index;
    logic [63:0]                      tag;
    logic [63:0]                      data;
  } tlb_cmd_t;

  typedef struct packed {
    itlb_pkg::outcome_t outcome;
    logic [63:0]        phys;
    logic               exec;
    logic [3:0]         fsr;
    logic [63:0]        tag_acc;
  } tlb_result_t;

  typedef struct {
    logic                       set_cfg;
    logic                       en;
    logic [itlb_pkg::CTX_W-1:0] ctx;
    tlb_cmd_t                   cmd;
    logic                       typed;
    tlb_result_t                exp;
  } dir_row_t;

  localparam tlb_result_t NO_EXP = '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [itlb_pkg::CFG_IDX_W-1:0] cfg_index = itlb_pkg::REG_IMMU_ENABLE;
  logic [itlb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = MODE_FETCH;
  logic [63:0] in_virt_addr = '0;
  logic in_user_access = 1'b0;
  logic [5:0] in_entry_index = '0;
  logic [63:0] in_entry_tag = '0;
  logic [63:0] in_entry_data = '0;
  logic out_valid;
  logic [1:0] out_outcome;
  logic [63:0] out_phys_addr;
  logic out_exec_allowed;
  logic [3:0] out_fault_status_out;
  logic [63:0] out_tag_access_out;

  logic [63:0] shadow_tags [TLB_ENTRIES];
  logic [63:0] shadow_data [TLB_ENTRIES];
  logic [3:0] shadow_fsr = '0;
  logic [63:0] shadow_tag_access = '0;
  logic shadow_immu_en = 1'b0;
  logic [itlb_pkg::CTX_W-1:0] shadow_ctx = '0;
  logic [63:0] page_mask [4] = '{itlb_pkg::MASK_8K, itlb_pkg::MASK_64K,
                                 itlb_pkg::MASK_512K, itlb_pkg::MASK_4M};

  tlb_result_t expected_results [$];
  dir_row_t directed [N_DIRECTED];
  int failures = 0;
  int idle_cycles = 0;
  int n_items = 0;
  int n_translated = 0;
  int n_faults = 0;
  int n_misses = 0;
  int n_writes = 0;

  instruction_tlb_lookup #(.TLB_ENTRIES(TLB_ENTRIES)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_virt_addr(in_virt_addr),
    .in_user_access(in_user_access),
    .in_entry_index(in_entry_index),
    .in_entry_tag(in_entry_tag),
    .in_entry_data(in_entry_data),
    .out_valid(out_valid),
    .out_outcome(out_outcome),
    .out_phys_addr(out_phys_addr),
    .out_exec_allowed(out_exec_allowed),
    .out_fault_status_out(out_fault_status_out),
    .out_tag_access_out(out_tag_access_out)
  );

  always #5 clk = ~clk;

  function automatic tlb_result_t predict_translation(input tlb_cmd_t c);
    tlb_result_t r;
    logic [63:0] m;
    logic [63:0] pa;
    logic hit;
    int i;
    r = NO_EXP;
    hit = 1'b0;
    if (c.mode == MODE_WRITE) begin
      shadow_tags[c.index] = c.tag;
      shadow_data[c.index] = c.data;
    end else if (!shadow_immu_en) begin
      r.phys = c.va;
      r.exec = 1'b1;
    end else begin
      for (i = 0; i < TLB_ENTRIES; i++) begin
        m = page_mask[shadow_data[i][itlb_pkg::SIZE_POS +: 2]];
        if (!hit && shadow_data[i][itlb_pkg::VALID_POS] &&
            shadow_tags[i][itlb_pkg::CTX_W-1:0] == shadow_ctx &&
            (c.va & m) == (shadow_tags[i] & m)) begin
          hit = 1'b1;
          if (shadow_data[i][itlb_pkg::PRIV_POS] && c.user) begin
            if (shadow_fsr != 4'h0) begin
              shadow_fsr = itlb_pkg::FSR_OVERFLOW;
            end
            shadow_fsr = shadow_fsr | itlb_pkg::FSR_PROT;
            r.outcome = itlb_pkg::OUT_FAULT;
          end else begin
            pa = ((shadow_data[i] & m) | (c.va & ~m)) & PA_MASK;
            r.phys = pa;
            r.exec = 1'b1;
          end
        end
      end
      if (!hit) begin
        shadow_tag_access = {c.va[63:itlb_pkg::CTX_W], shadow_ctx};
        r.outcome = itlb_pkg::OUT_MISS;
      end
    end
    r.fsr = shadow_fsr;
    r.tag_acc = shadow_tag_access;
    return r;
  endfunction

  function automatic int unsigned pick_gap(input logic burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, MAX_GAP);
  endfunction

  // Drive one transaction, hold it until accepted, then queue its expected result.
  task automatic issue(input tlb_cmd_t c, input int unsigned gap, input logic typed,
                       input tlb_result_t typed_exp);
    tlb_result_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= c.mode;
    in_virt_addr <= c.va;
    in_user_access <= c.user;
    in_entry_index <= c.index;
    in_entry_tag <= c.tag;
    in_entry_data <= c.data;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_translation(c);
    expected_results.push_back(typed ? typed_exp : predicted);
    n_items++;
    if (c.mode == MODE_WRITE) n_writes++;
    else if (predicted.outcome == itlb_pkg::OUT_FAULT) n_faults++;
    else if (predicted.outcome == itlb_pkg::OUT_MISS) n_misses++;
    else n_translated++;
  endtask

  // Drain outstanding results, then write both registers.
  task automatic write_regs(input logic en, input logic [itlb_pkg::CTX_W-1:0] ctx);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= itlb_pkg::REG_IMMU_ENABLE;
    cfg_wdata <= {itlb_pkg::CFG_DATA_W'($urandom_range(0, 4095)) << 1} |
                 itlb_pkg::CFG_DATA_W'(en);
    @(posedge clk);
    shadow_immu_en = en;
    cfg_index <= itlb_pkg::REG_CURRENT_CONTEXT;
    cfg_wdata <= ctx;
    @(posedge clk);
    shadow_ctx = ctx;
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: outcome=%0d pa=%h", out_outcome,
                                     out_phys_addr);
      end else begin
        tlb_result_t e;
        e = expected_results.pop_front();
        if (out_outcome !== e.outcome || out_phys_addr !== e.phys ||
            out_exec_allowed !== e.exec || out_fault_status_out !== e.fsr ||
            out_tag_access_out !== e.tag_acc) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch exp: outcome=%0d pa=%h exec=%0b fsr=%h tag=%h",
                     e.outcome, e.phys, e.exec, e.fsr, e.tag_acc);
            $display("         got: outcome=%0d pa=%h exec=%0b fsr=%h tag=%h",
                     out_outcome, out_phys_addr, out_exec_allowed, out_fault_status_out,
                     out_tag_access_out);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    tlb_cmd_t c;
    logic burst;
    logic [itlb_pkg::CTX_W-1:0] ctx;
    logic [63:0] m;
    int unsigned p, n, k;

    for (k = 0; k < TLB_ENTRIES; k++) begin
      shadow_tags[k] = '0;
      shadow_data[k] = '0;
    end

    directed = '{
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b1, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, '1, 1'b1, 6'd63, '1, '1},
        1'b1, '{itlb_pkg::OUT_OK, 64'hffff_ffff_ffff_ffff, 1'b1, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd63, '1, '1},
        1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd0, 64'h0000_0000_0040_0005,
        64'h8000_0000_1234_6000}, 1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd1, 64'h0000_0000_0040_0005,
        64'h8000_0000_0abc_0000}, 1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd2, 64'h0000_0001_0001_0005,
        64'ha000_01ff_fff0_0004}, 1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd3, 64'hffff_ffff_fff8_0000,
        64'hc000_0000_7778_0000}, 1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'h0, 64'h0}},
      '{1'b1, 1'b1, 13'h5, '{MODE_FETCH, 64'h0000_0000_0040_1abc, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0000_0000_0040_1abc, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0000_0001_0001_f123, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_FAULT, 64'h0, 1'b0, 4'h9, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0000_0001_0001_f123, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_FAULT, 64'h0, 1'b0, 4'hb, 64'h0}},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0000_0001_0001_f123, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, '1, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_MISS, 64'h0, 1'b0, 4'hb, 64'hffff_ffff_ffff_e005}},
      '{1'b1, 1'b1, 13'h1fff, '{MODE_FETCH, '1, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, '1, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_FAULT, 64'h0, 1'b0, 4'hb, 64'hffff_ffff_ffff_e005}},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd63, '1, 64'h0},
        1'b1, '{itlb_pkg::OUT_OK, 64'h0, 1'b0, 4'hb, 64'hffff_ffff_ffff_e005}},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, '1, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_MISS, 64'h0, 1'b0, 4'hb, 64'hffff_ffff_ffff_ffff}},
      '{1'b0, 1'b0, 13'h0, '{MODE_FETCH, 64'h0, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b1, '{itlb_pkg::OUT_MISS, 64'h0, 1'b0, 4'hb, 64'h0000_0000_0000_1fff}},
      '{1'b1, 1'b1, 13'h0, '{MODE_FETCH, 64'hffff_ffff_fffa_bcde, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b0, 1'b0, 13'h0, '{MODE_WRITE, 64'h0, 1'b0, 6'd0, 64'h0000_0000_0040_0005, 64'h0},
        1'b0, NO_EXP},
      '{1'b1, 1'b1, 13'h5, '{MODE_FETCH, 64'h0000_0000_0040_0000, 1'b0, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP},
      '{1'b1, 1'b0, 13'h0, '{MODE_FETCH, 64'h1234_5678_9abc_def0, 1'b1, 6'd0, 64'h0, 64'h0},
        1'b0, NO_EXP}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < N_DIRECTED; k++) begin
      if (directed[k].set_cfg) write_regs(directed[k].en, directed[k].ctx);
      issue(directed[k].cmd, pick_gap(1'b0), directed[k].typed, directed[k].exp);
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: ctx = '0;
        1: ctx = '1;
        default: ctx = itlb_pkg::CTX_W'($urandom_range(0, 8191));
      endcase
      write_regs($urandom_range(0, 4) != 0, ctx);
      burst = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        c.va = {$urandom, $urandom};
        c.user = 1'($urandom_range(0, 1));
        c.index = itlb_pkg::ENTRY_IDX_W'($urandom_range(0, TLB_ENTRIES - 1));
        c.tag = {$urandom, $urandom};
        c.data = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 30) begin
          c.mode = MODE_WRITE;
          if ($urandom_range(0, 9) != 0) c.tag[itlb_pkg::CTX_W-1:0] = shadow_ctx;
          c.data[itlb_pkg::VALID_POS] = ($urandom_range(0, 99) < 85);
        end else begin
          c.mode = MODE_FETCH;
          // aim most fetches at an entry's page so hits and faults are frequent
          if ($urandom_range(0, 99) < 70) begin
            k = $urandom_range(0, TLB_ENTRIES - 1);
            m = page_mask[shadow_data[k][itlb_pkg::SIZE_POS +: 2]];
            c.va = (shadow_tags[k] & m) | (c.va & ~m);
          end
        end
        issue(c, pick_gap(burst), 1'b0, NO_EXP);
      end
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TLB_ENTRIES + 5) @(posedge clk);
    if (expected_results.size() != 0) failures++;

    $display("Ran %0d transactions over %0d register settings: %0d entry writes,",
             n_items, RANDOM_PHASES + 6, n_writes);
    $display("%0d translations, %0d protection faults, %0d misses; %0d failures",
             n_translated, n_faults, n_misses, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
